### rtl/mbfw_pkg.sv
// ----------------------------------------------------------------------------
// mbfw_pkg
// Shared types and constants of the MSB-first bit field writer.
// ----------------------------------------------------------------------------
package mbfw_pkg;

	localparam int BUFFER_BYTES   = 1024;
	localparam int MAX_FIELD_BITS = 32;
	localparam int WORD_BITS      = 32;
	localparam int WORDS          = BUFFER_BYTES / 4;
	localparam int WADDR_W        = $clog2(WORDS);
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

	localparam logic [10:0] CFG_LEN_RESET = 11'd1024;

	localparam logic [1:0] ACT_APPEND  = 2'd0;
	localparam logic [1:0] ACT_WRITE   = 2'd1;
	localparam logic [1:0] ACT_READ    = 2'd2;
	localparam logic [1:0] ACT_RESTART = 2'd3;

	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_ZERO_LEN = 2'd1;
	localparam logic [1:0] ERR_TOO_MANY = 2'd2;

	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  field_len;
		logic [31:0] field_value;
		logic [12:0] bit_position;
		logic [9:0]  byte_address;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [13:0] bit_cursor;
		logic [1:0]  error_code;
	} result_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [12:0] bit_start;
		logic [5:0]  field_len;
		logic [31:0] field_value;
		logic [9:0]  byte_address;
		logic [13:0] bit_cursor;
		logic [1:0]  error_code;
	} cmd_t;

endpackage

### rtl/mbfw_front.sv
// ----------------------------------------------------------------------------
// mbfw_front
// Accepts transactions, checks field length and range, tracks the cursor
// and sticky status, and issues memory commands to the queue.
// ----------------------------------------------------------------------------
module mbfw_front import mbfw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	input  logic        queue_full,
	input  logic        init_busy,
	output logic        cmd_push,
	output cmd_t        cmd
);

	logic [10:0] len_cfg_q;
	logic [13:0] cursor_q;
	logic [1:0]  status_q;
	logic [10:0] usable;
	logic [13:0] limit;
	logic [13:0] start;
	logic [14:0] end_bits;
	logic [13:0] nxt_cursor;
	logic [1:0]  nxt_status;
	logic [1:0]  op;

	assign item_stall = queue_full | init_busy;
	assign cmd_push   = item_valid & ~item_stall;

	assign usable = (len_cfg_q > 11'(BUFFER_BYTES)) ? 11'(BUFFER_BYTES) : len_cfg_q;
	assign limit  = {usable, 3'b000};

	always_comb begin
		start      = (item.action == ACT_APPEND) ? cursor_q : {1'b0, item.bit_position};
		end_bits   = {1'b0, start} + 15'(item.field_len);
		nxt_cursor = cursor_q;
		nxt_status = status_q;
		op         = OP_NONE;
		case (item.action)
			ACT_APPEND, ACT_WRITE: begin
				if (item.field_len == 8'd0) begin
					nxt_status = ERR_ZERO_LEN;
				end else if (item.field_len > 8'(MAX_FIELD_BITS) || end_bits > {1'b0, limit}) begin
					nxt_status = ERR_TOO_MANY;
				end else begin
					op = OP_WRITE;
					if (item.action == ACT_APPEND) begin
						nxt_cursor = cursor_q + 14'(item.field_len);
					end
				end
			end
			ACT_READ: begin
				if ({1'b0, item.byte_address} < usable) begin
					op = OP_READ;
				end
			end
			default: begin
				op         = OP_CLEAR;
				nxt_cursor = '0;
				nxt_status = ERR_OK;
			end
		endcase
	end

	always_comb begin
		cmd              = '0;
		cmd.op           = op;
		cmd.bit_start    = start[12:0];
		cmd.field_len    = item.field_len[5:0];
		cmd.field_value  = item.field_value;
		cmd.byte_address = item.byte_address;
		cmd.bit_cursor   = nxt_cursor;
		cmd.error_code   = nxt_status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q <= CFG_LEN_RESET;
			cursor_q  <= '0;
			status_q  <= ERR_OK;
		end else begin
			if (cfg_wr_en) begin
				len_cfg_q <= cfg_wr_data;
			end
			if (cmd_push) begin
				cursor_q <= nxt_cursor;
				status_q <= nxt_status;
			end
		end
	end

endmodule

### rtl/mbfw_fifo.sv
// ----------------------------------------------------------------------------
// mbfw_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module mbfw_fifo import mbfw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output cmd_t pop_data,
	output logic full,
	output logic empty
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/mbfw_back.sv
// ----------------------------------------------------------------------------
// mbfw_back
// Executes queued commands on a single-port word memory: field merge by
// read-modify-write of two words, byte read back, clearing sweep, and the
// result register.
// ----------------------------------------------------------------------------
module mbfw_back import mbfw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    queue_empty,
	input  cmd_t    head,
	output logic    pop,
	output logic    init_busy,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam logic [3:0] ST_INIT = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_RD0  = 4'd2;
	localparam logic [3:0] ST_RD1  = 4'd3;
	localparam logic [3:0] ST_WR0  = 4'd4;
	localparam logic [3:0] ST_WR1  = 4'd5;
	localparam logic [3:0] ST_CLR  = 4'd6;
	localparam logic [3:0] ST_DONE = 4'd7;

	logic [3:0]           state_q;
	cmd_t                 cur_q;
	logic [WADDR_W-1:0]   word_q;
	logic [1:0]           byte_sel_q;
	logic [63:0]          field_q;
	logic [63:0]          mask_q;
	logic [31:0]          hi_q;
	logic [WADDR_W-1:0]   clr_cnt_q;
	logic                 result_valid_q;
	result_t              result_q;

	logic [WORD_BITS-1:0] mem_q [WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic [WADDR_W-1:0]   mem_addr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_we;
	logic                 mem_re;

	logic [5:0]           shamt;
	logic [31:0]          len_mask;
	logic [31:0]          rd_word;
	logic [7:0]           rd_byte;
	logic                 spans;
	logic                 load_result;
	logic                 clr_last;

	assign init_busy    = (state_q == ST_INIT);
	assign pop          = (state_q == ST_IDLE) & ~queue_empty;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign shamt    = 6'(7'd64 - 7'(head.bit_start[4:0]) - 7'(head.field_len));
	assign len_mask = (head.field_len >= 6'(WORD_BITS)) ? '1 : ((32'd1 << head.field_len) - 32'd1);
	assign spans    = (mask_q[31:0] != '0);
	assign clr_last = (clr_cnt_q == WADDR_W'(WORDS - 1));

	assign rd_word     = rdata_q >> {~byte_sel_q, 3'b000};
	assign rd_byte     = rd_word[7:0];
	assign load_result = (state_q == ST_DONE) & (~result_valid_q | ~result_stall);

	always_comb begin
		mem_addr  = word_q;
		mem_wdata = '0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		case (state_q)
			ST_INIT, ST_CLR: begin
				mem_addr = clr_cnt_q;
				mem_we   = 1'b1;
			end
			ST_RD0: begin
				mem_re = 1'b1;
			end
			ST_RD1: begin
				mem_addr = word_q + 1'b1;
				mem_re   = 1'b1;
			end
			ST_WR0: begin
				mem_addr  = word_q + 1'b1;
				mem_wdata = (rdata_q & ~mask_q[31:0]) | field_q[31:0];
				mem_we    = spans;
			end
			ST_WR1: begin
				mem_wdata = (hi_q & ~mask_q[63:32]) | field_q[63:32];
				mem_we    = 1'b1;
			end
			default: begin
				mem_addr = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q   <= head;
			field_q <= {32'd0, head.field_value & len_mask} << shamt;
			mask_q  <= {32'd0, len_mask} << shamt;
			if (head.op == OP_READ) begin
				word_q <= head.byte_address[2 +: WADDR_W];
			end else begin
				word_q <= head.bit_start[5 +: WADDR_W];
			end
			byte_sel_q <= head.byte_address[1:0];
		end
		if (state_q == ST_RD1) begin
			hi_q <= rdata_q;
		end
		if (load_result) begin
			result_q.read_data  <= (cur_q.op == OP_READ) ? rd_byte : 8'd0;
			result_q.bit_cursor <= cur_q.bit_cursor;
			result_q.error_code <= cur_q.error_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_INIT;
			clr_cnt_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						case (head.op)
							OP_WRITE: state_q <= ST_RD0;
							OP_READ:  state_q <= ST_RD0;
							OP_CLEAR: state_q <= ST_CLR;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_RD0: begin
					state_q <= (cur_q.op == OP_READ) ? ST_DONE : ST_RD1;
				end
				ST_RD1: begin
					state_q <= ST_WR0;
				end
				ST_WR0: begin
					state_q <= ST_WR1;
				end
				ST_WR1: begin
					state_q <= ST_DONE;
				end
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_result) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/msb_first_bit_field_writer_core.sv
// ----------------------------------------------------------------------------
// msb_first_bit_field_writer_core
// Packs 1 to 32 bit fields MSB first into a 1024 byte buffer.
// ----------------------------------------------------------------------------
// Each transaction yields one result. A front stage checks the field and
// updates cursor and status in the cycle it accepts a transaction and hands
// a command to a two-entry queue; the back stage runs commands one at a time
// on a single-port 256 x 32 memory (buffer byte 0 in bits 31:24 of word 0).
// Append and positional write pop, read both words the field may touch,
// write both back and load the result register; a byte read pops, reads
// its word and loads the result; a rejected field goes from pop to the
// result; a restart runs the 256-word clearing sweep, which also runs after
// reset with item_stall high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module msb_first_bit_field_writer_core import mbfw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result
);

	logic cmd_push;
	cmd_t cmd;
	logic queue_full;
	logic queue_empty;
	logic pop;
	cmd_t head;
	logic init_busy;

	mbfw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.queue_full  (queue_full),
		.init_busy   (init_busy),
		.cmd_push    (cmd_push),
		.cmd         (cmd)
	);

	mbfw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd),
		.pop       (pop),
		.pop_data  (head),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	mbfw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (queue_empty),
		.head         (head),
		.pop          (pop),
		.init_busy    (init_busy),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### rtl/mbfw_checker.sv
// ----------------------------------------------------------------------------
// mbfw_checker
// Port-level checks of the bit field writer, bound to the top level.
// ----------------------------------------------------------------------------
module mbfw_checker import mbfw_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input result_t     result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result transaction changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.error_code != 2'd3)
		else $error("illegal status code");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.bit_cursor <= 14'(8 * BUFFER_BYTES))
		else $error("cursor beyond buffer");

	a_init_stall: assert property (@(posedge clk)
		$rose(arst_n) |-> item_stall && !result_valid)
		else $error("transaction accepted during clearing pass");

endmodule

bind msb_first_bit_field_writer_core mbfw_checker u_mbfw_checker (.*);

### tb/sv/mbfw_checker.sv
// ----------------------------------------------------------------------------
// mbfw_tb_checker
// Predicts and checks every result of the MSB-first bit field writer.
// ----------------------------------------------------------------------------
// Watches the configuration port and both channels. Each accepted input
// transaction runs through a bit-level model of the byte store, the cursor
// and the sticky status. The predicted result goes into a queue. Each
// accepted result is compared field by field with the oldest entry in that
// queue. The failure count and the number of outstanding results go back
// to the testbench top.
// ----------------------------------------------------------------------------
module mbfw_tb_checker import mbfw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,
	input  logic        item_valid,
	input  logic        item_stall,
	input  item_t       item,
	input  logic        result_valid,
	input  logic        result_stall,
	input  result_t     result,
	output int          fail_count,
	output int          pending_count
);

	logic [7:0]  model_bytes [0:BUFFER_BYTES-1];
	logic [13:0] model_cursor;
	logic [1:0]  model_status;
	logic [10:0] model_len;
	result_t     pending_results [$];
	result_t     want;

	function automatic int usable_bytes();
		return (int'(model_len) > BUFFER_BYTES) ? BUFFER_BYTES : int'(model_len);
	endfunction

	function automatic bit field_fits(int start, int len);
		if (len == 0) begin
			model_status = ERR_ZERO_LEN;
			return 1'b0;
		end
		if (len > MAX_FIELD_BITS) begin
			model_status = ERR_TOO_MANY;
			return 1'b0;
		end
		if (start + len > 8 * usable_bytes()) begin
			model_status = ERR_TOO_MANY;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void store_field(int start, int len, logic [31:0] value);
		int p;
		for (int i = 0; i < len; i++) begin
			p = start + i;
			if ((p >> 3) < BUFFER_BYTES)
				model_bytes[p >> 3][7 - (p & 7)] = value[len - 1 - i];
		end
	endfunction

	function automatic void clear_store();
		foreach (model_bytes[i])
			model_bytes[i] = '0;
		model_cursor = '0;
		model_status = ERR_OK;
	endfunction

	function automatic result_t pack_field_item(item_t it);
		result_t r;
		r.read_data = '0;
		case (it.action)
			ACT_APPEND: begin
				if (field_fits(int'(model_cursor), int'(it.field_len))) begin
					store_field(int'(model_cursor), int'(it.field_len), it.field_value);
					model_cursor = model_cursor + 14'(it.field_len);
				end
			end
			ACT_WRITE: begin
				if (field_fits(int'(it.bit_position), int'(it.field_len)))
					store_field(int'(it.bit_position), int'(it.field_len), it.field_value);
			end
			ACT_READ: begin
				if (int'(it.byte_address) < usable_bytes())
					r.read_data = model_bytes[it.byte_address];
			end
			default: begin
				clear_store();
			end
		endcase
		r.bit_cursor = model_cursor;
		r.error_code = model_status;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_store();
			model_len = CFG_LEN_RESET;
			pending_results.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (cfg_wr_en)
				model_len = cfg_wr_data;
			if (result_valid && !result_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result rd=%h cur=%0d err=%0d", $time,
						result.read_data, result.bit_cursor, result.error_code);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (result.read_data !== want.read_data ||
					    result.bit_cursor !== want.bit_cursor ||
					    result.error_code !== want.error_code) begin
						$display("%0t: mismatch expected rd=%h cur=%0d err=%0d,",
							$time, want.read_data, want.bit_cursor, want.error_code,
							" got rd=%h cur=%0d err=%0d",
							result.read_data, result.bit_cursor, result.error_code);
						fail_count++;
					end
				end
			end
			if (item_valid && !item_stall)
				pending_results.push_back(pack_field_item(item));
			pending_count = pending_results.size();
		end
	end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for msb_first_bit_field_writer_core.
// ----------------------------------------------------------------------------
// A directed run covers the field length limits, every action, the end of
// the buffer, the shortest buffer and a length change under a full cursor.
// Random transactions follow in three idling phases, with the buffer length
// changed between blocks once the block has drained. One long receiver
// hold-off backs the block up into its input. The checker predicts and
// compares; this module only drives and reports.
// ----------------------------------------------------------------------------
module tb;
	import mbfw_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [10:0] cfg_wr_data;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	int          fail_count;
	int          pending_count;

	int          src_idle_pct;
	int          sink_stall_pct;
	int          len_now;
	bit          hold_off_req;
	bit          hold_taken;
	int          hold_left;

	msb_first_bit_field_writer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	mbfw_tb_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3200000;
		$display("tb: done, errors");
		$finish;
	end

	// receiver: random stall, or a counted hold-off on request
	initial begin
		result_stall = 1'b0;
		hold_left = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(0, 99) < sink_stall_pct);
			end
		end
	end

	function automatic item_t mk(logic [1:0] act, int len, logic [31:0] val, int pos, int addr);
		item_t it;
		it.action       = act;
		it.field_len    = 8'(len);
		it.field_value  = val;
		it.bit_position = 13'(pos);
		it.byte_address = 10'(addr);
		return it;
	endfunction

	function automatic item_t rand_item();
		int r;
		int s;
		logic [1:0] act;
		int len;
		int pos;
		int addr;
		r = $urandom_range(0, 99);
		if (r < 45)
			act = ACT_APPEND;
		else if (r < 70)
			act = ACT_WRITE;
		else if (r < 93)
			act = ACT_READ;
		else
			act = ACT_RESTART;
		s = $urandom_range(0, 99);
		if (s < 4)
			len = 0;
		else if (s < 10)
			len = $urandom_range(33, 255);
		else if (s < 40)
			len = $urandom_range(1, 8);
		else
			len = $urandom_range(1, 32);
		if ($urandom_range(0, 9) < 7)
			pos = $urandom_range(0, 8 * len_now - 1);
		else
			pos = $urandom_range(0, 8191);
		if ($urandom_range(0, 9) < 7)
			addr = $urandom_range(0, len_now - 1);
		else
			addr = $urandom_range(0, 1023);
		return mk(act, len, $urandom, pos, addr);
	endfunction

	function automatic int pick_len();
		case ($urandom_range(0, 9))
			0:       return 1;
			1:       return 1024;
			2, 3, 4, 5, 6: return $urandom_range(2, 16);
			7:       return $urandom_range(17, 64);
			default: return $urandom_range(1, 1024);
		endcase
	endfunction

	// called just after a falling edge; returns at the falling edge after acceptance
	task automatic push_item(input item_t it);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_buffer_len(input int n);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= 11'(n);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		len_now = n;
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = CFG_LEN_RESET;
		hold_off_req = 1'b0;
		len_now = 1024;
		src_idle_pct = 16;
		sink_stall_pct = 67;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_item(mk(ACT_APPEND, 1, 32'h0000_0001, 0, 0));
		push_item(mk(ACT_APPEND, 32, 32'hffff_ffff, 0, 0));
		push_item(mk(ACT_APPEND, 0, 32'hffff_ffff, 0, 0));
		push_item(mk(ACT_APPEND, 33, 32'h1234_5678, 0, 0));
		push_item(mk(ACT_APPEND, 255, 32'h0, 0, 0));
		push_item(mk(ACT_WRITE, 32, 32'ha5a5_5a5a, 0, 0));
		push_item(mk(ACT_WRITE, 1, 32'hffff_ffff, 8191, 0));
		push_item(mk(ACT_WRITE, 4, 32'hf, 8190, 0));
		push_item(mk(ACT_WRITE, 32, 32'hffff_ffff, 8191, 0));
		push_item(mk(ACT_READ, 0, 32'h0, 0, 0));
		push_item(mk(ACT_READ, 0, 32'h0, 0, 4));
		push_item(mk(ACT_READ, 0, 32'h0, 0, 1023));
		push_item(mk(ACT_RESTART, 0, 32'h0, 0, 0));
		push_item(mk(ACT_READ, 0, 32'h0, 0, 1023));
		push_item(mk(ACT_APPEND, 8, 32'h0000_0123, 0, 0));
		push_item(mk(ACT_WRITE, 2, 32'h0, 3, 0));
		push_item(mk(ACT_READ, 0, 32'h0, 0, 0));
		drain();
		// cursor now sits at the end of a one-byte buffer
		set_buffer_len(1);
		push_item(mk(ACT_APPEND, 1, 32'h1, 0, 0));
		push_item(mk(ACT_RESTART, 0, 32'h0, 0, 0));
		push_item(mk(ACT_APPEND, 8, 32'h5a, 0, 0));
		push_item(mk(ACT_APPEND, 1, 32'h1, 0, 0));
		push_item(mk(ACT_WRITE, 8, 32'hc3, 0, 0));
		push_item(mk(ACT_READ, 0, 32'h0, 0, 0));
		push_item(mk(ACT_READ, 0, 32'h0, 0, 1));
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 16;
					sink_stall_pct = 67;
				end
				1: begin
					src_idle_pct = 67;
					sink_stall_pct = 16;
				end
				default: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				drain();
				if (blk == 0)
					set_buffer_len(phase == 1 ? 1 : 1024);
				else
					set_buffer_len(pick_len());
				if (phase == 2 && blk == 1)
					hold_off_req = 1'b1;
				for (int n = 0; n < 35; n++)
					push_item(rand_item());
			end
		end

		drain();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
